FILE: rtl/hbc_pkg.sv
package hbc_pkg;

   // field widths
   localparam int TIME_W   = 48;
   localparam int AXIS_W   = 12;
   localparam int GYRO_W   = 16;
   localparam int CFG_W    = 16;
   localparam int PROG_W   = 7;
   localparam int PHASE_W  = 3;
   localparam int N_AXES   = 4;
   localparam int N_GYROS  = 3;
   localparam int AXACC_W  = 28;
   localparam int GYACC_W  = 33;

   // shared divider geometry
   localparam int DIV_N_W  = 48;
   localparam int DIV_D_W  = 20;
   localparam int DIV_C_W  = $clog2(DIV_N_W);

   // stream words
   localparam int REQ_W    = 152;
   localparam int RSP_W    = 112;

   // phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HOLD   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SAMPLE = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DONE   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CANCEL = 3'd4;

   // register indexes
   localparam logic REG_HOLD_MS      = 1'b0;
   localparam logic REG_SAMPLE_COUNT = 1'b1;

   localparam logic [CFG_W-1:0]   HOLD_MS_RST      = 16'd3000;
   localparam logic [CFG_W-1:0]   SAMPLE_COUNT_RST = 16'd200;
   localparam logic [AXIS_W-1:0]  CENTER_RST       = 12'd2048;
   localparam logic [PROG_W-1:0]  PROG_FULL        = 7'd100;
   localparam logic [DIV_D_W-1:0] BLINK_US         = 20'd250000;
   localparam logic [9:0]         MS_US            = 10'd1000;
   localparam logic [3:0]         MS_PCT           = 4'd10;

   // divider jobs; low two bits of an axis or gyro job select the lane
   typedef logic [3:0] job_type;
   localparam job_type JOB_AX0   = 4'd0;
   localparam job_type JOB_AX1   = 4'd1;
   localparam job_type JOB_AX2   = 4'd2;
   localparam job_type JOB_AX3   = 4'd3;
   localparam job_type JOB_GX    = 4'd4;
   localparam job_type JOB_GY    = 4'd5;
   localparam job_type JOB_GZ    = 4'd6;
   localparam job_type JOB_BLINK = 4'd7;
   localparam job_type JOB_HOLD  = 4'd8;
   localparam job_type JOB_PCT   = 4'd9;

   typedef struct packed {
      logic [TIME_W-1:0]                now_us;
      logic                             pressed;
      logic [N_AXES-1:0][AXIS_W-1:0]    axis;
      logic [N_GYROS-1:0][GYRO_W-1:0]   gyro;
   } item_type;

   typedef struct packed {
      logic [PHASE_W-1:0]               phase;
      logic [PROG_W-1:0]                progress;
      logic                             led_on;
      logic                             result_valid;
      logic [N_AXES-1:0][AXIS_W-1:0]    center;
      logic [N_GYROS-1:0][GYRO_W-1:0]   bias;
   } result_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/hbc_div.sv
// Restoring divider, one quotient bit per cycle.
module hbc_div
   import hbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_C_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] num_ff, num_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] den_ff, den_in;
   logic [DIV_D_W:0]   trial;
   logic               fits;

   assign trial = {rem_ff, num_ff[DIV_N_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = DIV_C_W'(DIV_N_W - 1);
         num_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the difference fits
         rem_in = fits ? DIV_D_W'(trial - {1'b0, den_ff}) : trial[DIV_D_W-1:0];
         num_in = {num_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");

endmodule

FILE: rtl/hbc_core.sv
// Calibration state and the sequencer that drives the shared divider.
module hbc_core
   import hbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  item_type         item,
   input  logic [CFG_W-1:0] hold_ms,
   input  logic [CFG_W-1:0] sample_count,
   input  logic             out_free,
   output logic             ready,
   output logic             res_valid,
   output result_type       result
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_ELAP    = 7'b0000010,
      ST_EVAL    = 7'b0000100,
      ST_SCHK    = 7'b0001000,
      ST_DIVGO   = 7'b0010000,
      ST_DIVWAIT = 7'b0100000,
      ST_EMIT    = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   item_type            item_ff, item_in;
   job_type             job_ff, job_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [TIME_W-1:0]   hold_start_ff, hold_start_in;
   logic [CFG_W-1:0]    taken_ff, taken_in;
   logic [CFG_W-1:0]    told_ff, told_in;
   logic [AXACC_W-1:0]  axis_acc_ff [N_AXES];
   logic [AXACC_W-1:0]  axis_acc_in [N_AXES];
   logic [GYACC_W-1:0]  gyro_acc_ff [N_GYROS];
   logic [GYACC_W-1:0]  gyro_acc_in [N_GYROS];
   logic [PROG_W-1:0]   progress_ff, progress_in;
   logic                led_ff, led_in;
   logic                valid_ff, valid_in;
   logic [AXIS_W-1:0]   centers_ff [N_AXES];
   logic [AXIS_W-1:0]   centers_in [N_AXES];
   logic [GYRO_W-1:0]   biases_ff [N_GYROS];
   logic [GYRO_W-1:0]   biases_in [N_GYROS];
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [25:0]         limit_ff, limit_in;
   logic [DIV_D_W-1:0]  hold_div_ff, hold_div_in;
   logic [CFG_W-1:0]    sc_ff, sc_in;
   logic                hold_end_ff, hold_end_in;

   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic [1:0]          gi;
   logic [GYACC_W-1:0]  gmag;
   logic [GYRO_W-1:0]   gq;

   hbc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // gyro lane of the current job; clamp keeps the index in range otherwise
   assign gi   = (job_ff[1:0] == 2'd3) ? 2'd2 : job_ff[1:0];
   assign gmag = gyro_acc_ff[gi][GYACC_W-1] ? (GYACC_W'(0) - gyro_acc_ff[gi])
                                            : gyro_acc_ff[gi];
   assign gq   = div_rsp.quotient[GYRO_W-1:0];

   // operand select for the divider
   always_comb begin
      div_req.start    = (state_ff == ST_DIVGO);
      div_req.dividend = elapsed_ff;
      div_req.divisor  = BLINK_US;
      case (job_ff)
         JOB_BLINK: begin
            div_req.dividend = elapsed_ff;
            div_req.divisor  = BLINK_US;
         end
         JOB_HOLD: begin
            div_req.dividend = elapsed_ff;
            div_req.divisor  = hold_div_ff;
         end
         JOB_PCT: begin
            div_req.dividend = DIV_N_W'(23'(told_ff) * 23'(PROG_FULL));
            div_req.divisor  = DIV_D_W'(sc_ff);
         end
         JOB_AX0, JOB_AX1, JOB_AX2, JOB_AX3: begin
            div_req.dividend = DIV_N_W'(axis_acc_ff[job_ff[1:0]]);
            div_req.divisor  = DIV_D_W'(taken_ff);
         end
         JOB_GX, JOB_GY, JOB_GZ: begin
            div_req.dividend = DIV_N_W'(gmag);
            div_req.divisor  = DIV_D_W'(taken_ff);
         end
         default: begin
            div_req.dividend = elapsed_ff;
            div_req.divisor  = BLINK_US;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      job_in        = job_ff;
      phase_in      = phase_ff;
      hold_start_in = hold_start_ff;
      taken_in      = taken_ff;
      told_in       = told_ff;
      progress_in   = progress_ff;
      led_in        = led_ff;
      valid_in      = valid_ff;
      elapsed_in    = elapsed_ff;
      limit_in      = limit_ff;
      hold_div_in   = hold_div_ff;
      sc_in         = sc_ff;
      hold_end_in   = hold_end_ff;
      res_valid     = 1'b0;
      for (int i = 0; i < N_AXES; i++) begin
         axis_acc_in[i] = axis_acc_ff[i];
         centers_in[i]  = centers_ff[i];
      end
      for (int i = 0; i < N_GYROS; i++) begin
         gyro_acc_in[i] = gyro_acc_ff[i];
         biases_in[i]   = biases_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_in  = item;
               state_in = ST_ELAP;
            end
         end
         ST_ELAP: begin
            elapsed_in  = item_ff.now_us - hold_start_ff;
            limit_in    = 26'(hold_ms) * 26'(MS_US);
            hold_div_in = DIV_D_W'(hold_ms) * DIV_D_W'(MS_PCT);
            sc_in       = (sample_count == '0) ? CFG_W'(1) : sample_count;
            state_in    = ST_EVAL;
         end
         ST_EVAL: begin
            case (phase_ff)
               PH_HOLD: begin
                  if (!item_ff.pressed) begin
                     phase_in    = PH_CANCEL;
                     progress_in = '0;
                     led_in      = 1'b1;
                     state_in    = ST_EMIT;
                  end else begin
                     hold_end_in = elapsed_ff >= TIME_W'(limit_ff);
                     job_in      = JOB_BLINK;
                     state_in    = ST_DIVGO;
                  end
               end
               PH_SAMPLE: begin
                  for (int i = 0; i < N_AXES; i++)
                     axis_acc_in[i] = axis_acc_ff[i] + AXACC_W'(item_ff.axis[i]);
                  for (int i = 0; i < N_GYROS; i++)
                     gyro_acc_in[i] = gyro_acc_ff[i] +
                        {{(GYACC_W-GYRO_W){item_ff.gyro[i][GYRO_W-1]}}, item_ff.gyro[i]};
                  told_in  = taken_ff;
                  taken_in = taken_ff + 1'b1;
                  state_in = ST_SCHK;
               end
               default: begin
                  if (item_ff.pressed) begin
                     phase_in      = PH_HOLD;
                     hold_start_in = item_ff.now_us;
                     progress_in   = '0;
                  end
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_SCHK: begin
            // enough readings: average them all, else just report progress
            job_in   = (taken_ff >= sc_ff) ? JOB_AX0 : JOB_PCT;
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            state_in = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (div_rsp.done) begin
               case (job_ff)
                  JOB_BLINK: begin
                     led_in = div_rsp.quotient[0];
                     if (hold_end_ff) begin
                        progress_in = PROG_FULL;
                        phase_in    = PH_SAMPLE;
                        taken_in    = '0;
                        for (int i = 0; i < N_AXES; i++) axis_acc_in[i] = '0;
                        for (int i = 0; i < N_GYROS; i++) gyro_acc_in[i] = '0;
                        state_in    = ST_EMIT;
                     end else begin
                        job_in   = JOB_HOLD;
                        state_in = ST_DIVGO;
                     end
                  end
                  JOB_HOLD, JOB_PCT: begin
                     progress_in = div_rsp.quotient[PROG_W-1:0];
                     state_in    = ST_EMIT;
                  end
                  JOB_AX0, JOB_AX1, JOB_AX2, JOB_AX3: begin
                     centers_in[job_ff[1:0]] = div_rsp.quotient[AXIS_W-1:0];
                     job_in   = job_ff + 1'b1;
                     state_in = ST_DIVGO;
                  end
                  JOB_GX, JOB_GY, JOB_GZ: begin
                     biases_in[gi] = gyro_acc_ff[gi][GYACC_W-1] ? (GYRO_W'(0) - gq) : gq;
                     if (job_ff == JOB_GZ) begin
                        valid_in    = 1'b1;
                        progress_in = PROG_FULL;
                        phase_in    = PH_DONE;
                        led_in      = 1'b1;
                        state_in    = ST_EMIT;
                     end else begin
                        job_in   = job_ff + 1'b1;
                        state_in = ST_DIVGO;
                     end
                  end
                  default: state_in = ST_EMIT;
               endcase
            end
         end
         ST_EMIT: begin
            res_valid = out_free;
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_IDLE;
         hold_start_ff <= '0;
         taken_ff      <= '0;
         progress_ff   <= '0;
         led_ff        <= 1'b0;
         valid_ff      <= 1'b0;
         for (int i = 0; i < N_AXES; i++) begin
            axis_acc_ff[i] <= '0;
            centers_ff[i]  <= CENTER_RST;
         end
         for (int i = 0; i < N_GYROS; i++) begin
            gyro_acc_ff[i] <= '0;
            biases_ff[i]   <= '0;
         end
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         hold_start_ff <= hold_start_in;
         taken_ff      <= taken_in;
         progress_ff   <= progress_in;
         led_ff        <= led_in;
         valid_ff      <= valid_in;
         for (int i = 0; i < N_AXES; i++) begin
            axis_acc_ff[i] <= axis_acc_in[i];
            centers_ff[i]  <= centers_in[i];
         end
         for (int i = 0; i < N_GYROS; i++) begin
            gyro_acc_ff[i] <= gyro_acc_in[i];
            biases_ff[i]   <= biases_in[i];
         end
      end
      item_ff     <= item_in;
      job_ff      <= job_in;
      told_ff     <= told_in;
      elapsed_ff  <= elapsed_in;
      limit_ff    <= limit_in;
      hold_div_ff <= hold_div_in;
      sc_ff       <= sc_in;
      hold_end_ff <= hold_end_in;
   end

   assign ready = (state_ff == ST_IDLE);

   always_comb begin
      result.phase        = phase_ff;
      result.progress     = progress_ff;
      result.led_on       = led_ff;
      result.result_valid = valid_ff;
      for (int i = 0; i < N_AXES; i++) result.center[i] = centers_ff[i];
      for (int i = 0; i < N_GYROS; i++) result.bias[i] = biases_ff[i];
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free && state_ff == ST_EMIT)
      else $error("word emitted into a full output stage");

   a_progress_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> progress_ff <= PROG_FULL)
      else $error("progress above full scale");

   a_valid_sticks: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> valid_ff)
      else $error("result_valid dropped");

   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> valid_ff)
      else $error("completed without a valid result");

endmodule

FILE: rtl/hold_then_average_calibrator.sv
// Channel  Ports        Dir  Word
// req      req_t*       in   one update tick: time, trigger, raw axes and gyros
// rsp      rsp_t*       out  calibration status after that tick
// csr      csr_*        in   0 hold_ms, 1 sample_count; write only
//
// One word at a time; req_tready is high only while the sequencer is idle.
// Ticks outside holding and sampling need no division. Every division runs on one
// shared 48-bit restoring divider: a holding tick divides for the blink and, unless
// the hold ends, for progress; a sampling tick once, the completing tick seven times.
// The output register lets the next word in while a status word waits on rsp.
// Reset is synchronous; it clears state, centers to 2048 and biases to 0.
module hold_then_average_calibrator
   import hbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // now_us[47:0], pressed[48], axis_0..axis_3[96:49], gyro_x..gyro_z[144:97]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // phase[2:0], progress[9:3], led_on[10], result_valid[11],
   // center_0..center_3[59:12], bias_x..bias_z[107:60]
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [CFG_W-1:0] csr_wdata
);

   logic [CFG_W-1:0] hold_ms_ff, hold_ms_in;
   logic [CFG_W-1:0] sample_count_ff, sample_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   item_type   item;
   result_type result;
   logic       core_ready;
   logic       res_valid;
   logic       out_free;

   always_comb begin
      item.now_us  = req_tdata[47:0];
      item.pressed = req_tdata[48];
      for (int i = 0; i < N_AXES; i++)
         item.axis[i] = req_tdata[49 + i*AXIS_W +: AXIS_W];
      for (int i = 0; i < N_GYROS; i++)
         item.gyro[i] = req_tdata[97 + i*GYRO_W +: GYRO_W];
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   hbc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (req_tvalid && core_ready),
      .item         (item),
      .hold_ms      (hold_ms_ff),
      .sample_count (sample_count_ff),
      .out_free     (out_free),
      .ready        (core_ready),
      .res_valid    (res_valid),
      .result       (result)
   );

   always_comb begin
      hold_ms_in      = hold_ms_ff;
      sample_count_in = sample_count_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_HOLD_MS:      hold_ms_in      = csr_wdata;
            REG_SAMPLE_COUNT: sample_count_in = csr_wdata;
            default:          hold_ms_in      = hold_ms_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0,
                         result.bias[2], result.bias[1], result.bias[0],
                         result.center[3], result.center[2],
                         result.center[1], result.center[0],
                         result.result_valid, result.led_on,
                         result.progress, result.phase};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ms_ff      <= HOLD_MS_RST;
         sample_count_ff <= SAMPLE_COUNT_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         hold_ms_ff      <= hold_ms_in;
         sample_count_ff <= sample_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = core_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
